>>> sv/ostt_pkg.sv
// Shared types, constants and token helper for the one-shot token table.
package ostt_pkg;

  localparam int TABLE_SLOTS = 32;
  localparam int TOKEN_BYTES = 8;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_CHECK     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_UNMATCHED = 2'd1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  typedef struct packed {
    logic [31:0] guid;
    logic [31:0] user;
    logic [31:0] clan;
    logic [63:0] token;
  } entry_t;

  typedef struct packed {
    logic        bypass_check;
    logic        accept_unmatched;
  } cfg_t;

  typedef struct packed {
    logic [31:0] guid;
    logic [31:0] user;
    logic [31:0] clan;
    logic        found;
    logic        accepted;
  } res_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } ram_req_t;

  // Keeps the bytes before the first zero byte, within TOKEN_BYTES; the rest read as zero.
  function automatic logic [63:0] norm_token(input logic [63:0] t);
    logic [63:0] r;
    logic        keep;
    r    = '0;
    keep = 1'b1;
    for (int i = 0; i < TOKEN_BYTES; i++) begin
      keep = keep & (t[8*i +: 8] != 8'h00);
      if (keep) begin
        r[8*i +: 8] = t[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

>>> sv/ostt_ram.sv
// Slot memory: one write port and one read port with registered read data.
module ostt_ram
  import ostt_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output entry_t   rd_data
);

  entry_t mem [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

>>> sv/ostt_ctrl.sv
// Sequencer: slot valid bits, insert and check scans, result and output registers.
module ostt_ctrl
  import ostt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_op,
  input  entry_t   in_entry,
  input  cfg_t     cfg,
  output ram_req_t ram_req,
  input  entry_t   ram_rd_data,
  output logic     out_valid,
  input  logic     out_ready,
  output res_t     out_res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_CHK  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]             state;
  logic [TABLE_SLOTS-1:0] valid;
  logic [SLOT_W-1:0]      idx;
  logic [SLOT_W-1:0]      idx_q;
  logic                   issue_done;
  logic                   rd_pend;
  entry_t                 item;
  res_t                   res;
  logic                   hit;
  logic                   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign hit      = rd_pend && valid[idx_q] && (ram_rd_data.token == item.token);

  always_comb begin
    ram_req         = '0;
    ram_req.wr_data = item;
    ram_req.rd_addr = idx;
    ram_req.wr_addr = idx;
    if (state == ST_INS) begin
      ram_req.wr_en = 1'b1;
      // A full table sends the new token to slot 0.
      if (valid[idx] && idx == LAST_SLOT) begin
        ram_req.wr_addr = '0;
      end
      if (valid[idx] && idx != LAST_SLOT) begin
        ram_req.wr_en = 1'b0;
      end
    end
    if (state == ST_CHK) begin
      ram_req.rd_en = !issue_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= '0;
      out_valid  <= 1'b0;
      idx        <= '0;
      issue_done <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            idx        <= '0;
            issue_done <= 1'b0;
            rd_pend    <= 1'b0;
            if (in_op == OP_INSERT) begin
              res   <= '0;
              state <= ST_INS;
            end else if (cfg.bypass_check) begin
              res.accepted <= 1'b1;
              res.found    <= 1'b0;
              res.clan     <= '0;
              res.user     <= '0;
              res.guid     <= '0;
              state        <= ST_DONE;
            end else begin
              res   <= '0;
              state <= ST_CHK;
            end
          end
        end
        ST_INS: begin
          if (!valid[idx]) begin
            valid[idx]   <= 1'b1;
            res.accepted <= 1'b1;
            state        <= ST_DONE;
          end else if (idx == LAST_SLOT) begin
            res.accepted <= 1'b1;
            state        <= ST_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_CHK: begin
          // Reads are issued one slot a cycle; each is compared when its data returns.
          if (!issue_done) begin
            idx_q   <= idx;
            rd_pend <= 1'b1;
            if (idx == LAST_SLOT) begin
              issue_done <= 1'b1;
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            rd_pend <= 1'b0;
          end
          if (hit) begin
            valid[idx_q] <= 1'b0;
            res.accepted <= 1'b1;
            res.found    <= 1'b1;
            res.clan     <= ram_rd_data.clan;
            res.user     <= ram_rd_data.user;
            res.guid     <= ram_rd_data.guid;
            state        <= ST_DONE;
          end else if (rd_pend && idx_q == LAST_SLOT) begin
            res.accepted <= cfg.accept_unmatched;
            state        <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.token <= norm_token(in_entry.token);
      item.clan  <= in_entry.clan;
      item.user  <= in_entry.user;
      item.guid  <= in_entry.guid;
    end
    if (state == ST_DONE && out_free) begin
      out_res <= res;
    end
  end

endmodule

>>> sv/one_shot_token_table_core.sv
// Top level of the one-shot token table: stream ports, configuration registers, slot memory.
//
// The table holds TABLE_SLOTS single-use tokens with three payload words each, in one
// synchronous memory; slot valid bits sit in flip-flops and are cleared by reset, so the
// block is usable in the cycle after reset. One request is worked on at a time. An insert
// walks the valid bits one slot a cycle from slot 0 until its result is registered; a
// check reads the memory one slot a cycle through its single read port, ending early at
// the first matching slot; a bypassed check goes straight to its result. A new request
// is taken while the previous result still waits in the output register. The user must
// write configuration through the cfg channel only while the block is idle; the block
// itself does not enforce this, and cfg_ready is always high.
module one_shot_token_table_core
  import ostt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [159:0]         s_axis_tdata,  // token[63:0], clan_in, user_in, guid_in
  input  logic [0:0]           s_axis_tuser,  // op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [103:0]         m_axis_tdata,  // accepted, found, clan_out, user_out,
                                              // guid_out, zero fill
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [0:0]           cfg_data
);

  cfg_t     cfg;
  ram_req_t ram_req;
  entry_t   ram_rd_data;
  entry_t   in_entry;
  res_t     out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bypass_check     <= 1'b0;
      cfg.accept_unmatched <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BYPASS_CHECK:     cfg.bypass_check     <= cfg_data[0];
        CFG_ACCEPT_UNMATCHED: cfg.accept_unmatched <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign in_entry.token = s_axis_tdata[63:0];
  assign in_entry.clan  = s_axis_tdata[95:64];
  assign in_entry.user  = s_axis_tdata[127:96];
  assign in_entry.guid  = s_axis_tdata[159:128];

  ostt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_op       (s_axis_tuser[0]),
    .in_entry    (in_entry),
    .cfg         (cfg),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_res     (out_res)
  );

  ostt_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  assign m_axis_tdata = {6'b0, out_res};

endmodule

>>> test/one_shot_token_table_core_tb.sv
// Self-checking testbench for the one-shot token table core, driven through its stream ports.
module one_shot_token_table_core_tb
  import ostt_pkg::*;
();

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Tracks the token slots and the register settings, and holds the replies still owed.
  class admission_ledger;
    logic        bypass_on;
    logic        miss_accept;
    bit          used[TABLE_SLOTS];
    logic [63:0] tok_mem[TABLE_SLOTS];
    logic [31:0] clan_mem[TABLE_SLOTS];
    logic [31:0] user_mem[TABLE_SLOTS];
    logic [31:0] guid_mem[TABLE_SLOTS];
    res_t        awaited[$];
    int          errors;
    int          replies;
    int          inserts;
    int          overwrites;
    int          hits;
    int          misses;
    int          bypassed;

    function new();
      bypass_on   = 1'b0;
      miss_accept = 1'b1;
      foreach (used[i]) used[i] = 1'b0;
      errors      = 0;
      replies     = 0;
      inserts     = 0;
      overwrites  = 0;
      hits        = 0;
      misses      = 0;
      bypassed    = 0;
    endfunction

    // Bytes from the first zero byte onwards do not belong to the token.
    static function logic [63:0] trim_token(logic [63:0] raw);
      logic [63:0] kept;
      int          n;
      kept = '0;
      n    = 0;
      while (n < TOKEN_BYTES && raw[8*n +: 8] != 8'h00) begin
        kept[8*n +: 8] = raw[8*n +: 8];
        n++;
      end
      return kept;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic value);
      case (idx)
        CFG_BYPASS_CHECK:     bypass_on   = value;
        CFG_ACCEPT_UNMATCHED: miss_accept = value;
        default: ;
      endcase
    endfunction

    function void note_request(logic op, logic [63:0] raw, logic [31:0] clan,
                               logic [31:0] user, logic [31:0] guid);
      res_t        r;
      logic [63:0] key;
      int          slot;
      r    = '0;
      key  = trim_token(raw);
      slot = -1;
      if (op == OP_INSERT) begin
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (!used[i] && slot < 0) slot = i;
        // A full table gives up slot 0, whatever it holds.
        if (slot < 0) begin
          slot = 0;
          overwrites++;
        end
        tok_mem[slot]  = key;
        clan_mem[slot] = clan;
        user_mem[slot] = user;
        guid_mem[slot] = guid;
        used[slot]     = 1'b1;
        r.accepted     = 1'b1;
        inserts++;
      end else if (bypass_on) begin
        r.accepted = 1'b1;
        bypassed++;
      end else begin
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (used[i] && tok_mem[i] == key && slot < 0) slot = i;
        if (slot >= 0) begin
          used[slot] = 1'b0;
          r.accepted = 1'b1;
          r.found    = 1'b1;
          r.clan     = clan_mem[slot];
          r.user     = user_mem[slot];
          r.guid     = guid_mem[slot];
          hits++;
        end else begin
          r.accepted = miss_accept;
          misses++;
        end
      end
      awaited.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (errors < 20) $display("MISMATCH at reply %0d: %s", replies, msg);
      errors++;
    endtask

    task check_reply(logic [103:0] d);
      res_t got;
      res_t want;
      got = d[97:0];
      if (awaited.size() == 0) begin
        report_mismatch("reply with no request outstanding");
      end else begin
        want = awaited.pop_front();
        if (got.accepted !== want.accepted)
          report_mismatch($sformatf("accepted %b, expected %b", got.accepted, want.accepted));
        if (got.found !== want.found)
          report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
        if (got.clan !== want.clan)
          report_mismatch($sformatf("clan_out %h, expected %h", got.clan, want.clan));
        if (got.user !== want.user)
          report_mismatch($sformatf("user_out %h, expected %h", got.user, want.user));
        if (got.guid !== want.guid)
          report_mismatch($sformatf("guid_out %h, expected %h", got.guid, want.guid));
      end
      replies++;
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [159:0]         s_axis_tdata;
  logic [0:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [103:0]         m_axis_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [0:0]           cfg_data;

  admission_ledger ledger;
  logic [63:0]     token_pool[$];

  one_shot_token_table_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // A clean token of random length, every byte before the terminator non-zero.
  function automatic logic [63:0] fresh_token();
    logic [63:0] t;
    int          len;
    t   = '0;
    len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) t[8*i +: 8] = 8'($urandom_range(1, 255));
    return t;
  endfunction

  // Fills random bytes behind the terminator, which must not change the match.
  function automatic logic [63:0] dress_token(logic [63:0] canon);
    logic [63:0] t;
    int          len;
    t   = canon;
    len = 0;
    while (len < 8 && canon[8*len +: 8] != 8'h00) len++;
    for (int i = len + 1; i < 8; i++)
      if ($urandom_range(0, 1) == 1) t[8*i +: 8] = 8'($urandom);
    return t;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        ledger.note_request(s_axis_tuser[0], s_axis_tdata[63:0], s_axis_tdata[95:64],
                            s_axis_tdata[127:96], s_axis_tdata[159:128]);
      if (cfg_valid && cfg_ready) ledger.note_config(cfg_index, cfg_data[0]);
      if (m_axis_tvalid && m_axis_tready) ledger.check_reply(m_axis_tdata);
    end
  end

  // Valid stays high across back-to-back requests; it is only lowered for a gap.
  task automatic send_request(logic op, logic [63:0] tok, logic [31:0] clan,
                              logic [31:0] user, logic [31:0] guid, int gap);
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {guid, user, clan, tok};
    do @(posedge clk); while (!s_axis_tready);
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_plain(logic op, logic [63:0] tok);
    send_request(op, tok, pick_word(), pick_word(), pick_word(), pick_gap());
  endtask

  task automatic drain_replies();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (ledger.awaited.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(logic bypass, logic accept);
    drain_replies();
    write_reg(CFG_BYPASS_CHECK, bypass);
    write_reg(CFG_ACCEPT_UNMATCHED, accept);
  endtask

  // Inserts and checks drawn from a small token pool, so that checks mostly hit.
  task automatic run_phase(int count, int insert_pct, int pool_size, bit no_gaps);
    logic [63:0] tok;
    logic        op;
    token_pool.delete();
    for (int k = 0; k < pool_size; k++) token_pool.push_back(fresh_token());
    for (int k = 0; k < count; k++) begin
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_CHECK;
      if ($urandom_range(0, 99) < 85)
        tok = dress_token(token_pool[$urandom_range(0, pool_size - 1)]);
      else
        tok = {$urandom, $urandom};
      send_request(op, tok, pick_word(), pick_word(), pick_word(),
                   no_gaps ? 0 : pick_gap());
    end
  endtask

  // Reply side: random back-pressure, one long hold-off while requests keep coming.
  initial begin
    int run;
    int gap;
    bit held;
    m_axis_tready = 1'b0;
    held          = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && ledger.replies >= HOLD_AFTER) begin
        held          = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      run = ($urandom_range(0, 15) == 0) ? 150 : $urandom_range(1, 20);
      repeat (run) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    ledger        = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset settings.
    send_plain(OP_CHECK, 64'h0);
    send_request(OP_INSERT, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, pick_gap());
    send_request(OP_INSERT, 64'h0, 32'h0, 32'h0, 32'h0, pick_gap());
    send_plain(OP_INSERT, 64'hDEAD_BEEF_1234_0041);
    send_request(OP_INSERT, 64'h0807_0605_0403_0201, 32'hA1, 32'hA2, 32'hA3, pick_gap());
    send_plain(OP_CHECK, 64'h0000_0000_0000_0041);
    // Same text before the terminator, but that slot has just been used up.
    send_plain(OP_CHECK, 64'h5500_0000_0000_0041);
    send_request(OP_INSERT, 64'h0807_0605_0403_0201, 32'hB1, 32'hB2, 32'hB3, pick_gap());
    send_plain(OP_CHECK, 64'h0807_0605_0403_0201);
    send_plain(OP_CHECK, 64'h0807_0605_0403_0201);
    send_plain(OP_CHECK, 64'hAB00_0000_0000_0000);
    send_plain(OP_CHECK, '1);
    send_plain(OP_INSERT, 64'h00FF_FFFF_FFFF_FFFF);
    drain_replies();
    write_reg(CFG_ACCEPT_UNMATCHED, 1'b0);
    send_plain(OP_CHECK, 64'h0000_0000_0000_1234);
    drain_replies();
    write_reg(CFG_BYPASS_CHECK, 1'b1);
    send_plain(OP_CHECK, 64'h00FF_FFFF_FFFF_FFFF);
    send_plain(OP_INSERT, 64'h0000_0000_0000_0077);
    drain_replies();
    write_reg(CFG_BYPASS_CHECK, 1'b0);
    write_reg(CFG_SPARE_LO, 1'b1);
    write_reg(CFG_SPARE_HI, 1'b1);
    send_plain(OP_CHECK, 64'h00FF_FFFF_FFFF_FFFF);
    send_plain(OP_CHECK, 64'h0000_0000_0000_0077);
    send_plain(OP_CHECK, 64'h0000_0000_0000_0077);

    // Random part: each phase runs after its own register setting.
    set_config(1'b0, 1'b1);
    run_phase(350, 60, 12, 1'b0);
    set_config(1'b0, 1'b0);
    run_phase(300, 50, 40, 1'b0);
    set_config(1'b1, 1'b0);
    run_phase(200, 40, 8, 1'b0);
    set_config(1'b1, 1'b1);
    run_phase(150, 50, 8, 1'b1);
    set_config(1'b0, 1'b1);
    run_phase(400, 85, 6, 1'b0);
    set_config(1'b0, 1'b0);
    run_phase(300, 45, 20, 1'b1);
    set_config(1'b0, 1'b1);
    run_phase(200, 55, 3, 1'b0);
    drain_replies();

    $display("Run covered %0d replies: %0d inserts, %0d of them over a full table,",
             ledger.replies, ledger.inserts, ledger.overwrites);
    $display("%0d consumed matches, %0d unmatched and %0d bypassed checks.",
             ledger.hits, ledger.misses, ledger.bypassed);
    if (ledger.errors == 0 && ledger.awaited.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
